@@ hdl/pdp_pkg.sv @@
// Package for the pixel depth packer: register and depth codes, the job record.
// Used by every module of the block except pdp_ram; depends on nothing.
package pdp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEPTH = 2'd0;
  localparam logic [1:0] REG_LSB   = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;

  // Output depth codes.
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_24 = 3'd4;

  // Item function codes.
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 2;

  // Number of bytes one job yields (1..9).
  typedef logic [3:0] run_count_t;

  // One unit of work for the back end: bytes beyond index 3 are zero.
  typedef struct packed {
    run_count_t       count;
    logic             row_end;
    logic [3:0][7:0]  bytes;
  } job_t;

endpackage

@@ hdl/pdp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pdp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pdp_queue.sv @@
// Short job queue between the front and back ends of the pixel depth packer.
// Depends on pdp_pkg for the job record and the queue depth.
module pdp_queue
  import pdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic valid
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          do_wr;
  logic          do_rd;

  assign full    = (fill == (PW+1)'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign rd_data = entries[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hdl/pdp_front.sv @@
// Front end of the pixel depth packer: configuration, palette, packing state.
// Classifies each item and turns each pixel that completes bytes into one job for the back end.
// Depends on pdp_pkg and pdp_ram.
module pdp_front
  import pdp_pkg::*;
#(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [7:0]            pixel,
  input  logic [7:0]            palette_index,
  input  logic [15:0]           red_level,
  input  logic [15:0]           green_level,
  input  logic [15:0]           blue_level,
  output logic                  q_wr_en,
  output job_t                  q_wr_data,
  input  logic                  q_full
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(PALETTE_ENTRIES);

  // Configuration registers.
  logic [2:0]            depth_code;
  logic                  lsb_first;
  logic [CFG_DATA_W-1:0] image_width;

  // Packing state; fill counts bits already placed in the open byte.
  logic [7:0]    acc;
  logic [2:0]    fill;
  logic [WW-1:0] column_count;

  // Stage between accept and queue push (palette read latency).
  logic       s1_valid;
  logic       s1_is24;
  logic       s1_lsb;
  logic       s1_in_range;
  logic       s1_row_end;
  run_count_t s1_count;
  logic [7:0] s1_val;

  logic          cfg_write;
  logic          accept;
  logic          s1_move;
  logic          pixel_go;
  logic          is_packed;
  logic          is_24;
  logic [1:0]    dlog;
  logic [3:0]    dbits;
  logic [WW-1:0] width_eff;
  logic [WW-1:0] col_inc;
  logic          row_end;
  logic [2:0]    bit_pos;
  logic [15:0]   shifted;
  logic [7:0]    val;
  logic [3:0]    fill_inc;
  logic [3:0]    pad;
  logic [6:0]    pad_bits;
  logic [6:0]    pad_total;
  run_count_t    n_pack;
  logic          gives_job;
  logic          pal_we;
  logic [23:0]   pal_rdata;
  logic [7:0]    red_top;
  logic [7:0]    green_top;
  logic [7:0]    blue_top;

  // Handshake.
  assign cfg_write = cfg_valid && (cfg_index == REG_DEPTH || cfg_index == REG_LSB ||
                                   cfg_index == REG_WIDTH);
  assign full      = s1_valid && q_full;
  assign accept    = push && !full;
  assign s1_move   = s1_valid && !q_full;

  // Depth decode.
  always_comb begin
    is_packed = 1'b0;
    is_24     = 1'b0;
    dlog      = 2'd0;
    unique case (depth_code)
      DEPTH_1:  begin is_packed = 1'b1; dlog = 2'd0; end
      DEPTH_2:  begin is_packed = 1'b1; dlog = 2'd1; end
      DEPTH_4:  begin is_packed = 1'b1; dlog = 2'd2; end
      DEPTH_8:  begin is_packed = 1'b1; dlog = 2'd3; end
      DEPTH_24: begin is_24 = 1'b1; end
      default:  begin is_packed = 1'b0; end
    endcase
  end
  assign dbits = 4'd1 << dlog;

  // Row width with zero taken as one and large values saturated.
  always_comb begin
    if (image_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width);
    end
  end
  assign col_inc = column_count + 1'b1;
  assign row_end = (col_inc >= width_eff);

  // Place the pixel; shifted bits above the byte are dropped.
  assign bit_pos  = lsb_first ? fill : 3'(4'd8 - dbits - {1'b0, fill});
  assign shifted  = {8'b0, pixel} << bit_pos;
  assign val      = acc | shifted[7:0];
  assign fill_inc = {1'b0, fill} + dbits;

  // Row padding: count bytes completed by the pixel and, at a row end, by the pad slots.
  assign pad       = 4'd8 - {1'b0, width_eff[2:0]};
  assign pad_bits  = 7'(pad) << dlog;
  assign pad_total = 7'(fill_inc[2:0]) + pad_bits;
  assign n_pack    = run_count_t'(fill_inc[3]) + (row_end ? pad_total[6:3] : 4'd0);

  assign pixel_go  = accept && (func == FUNC_PIXEL) && (is_packed || is_24);
  assign gives_job = is_24 || (n_pack != '0);

  // Configuration and packing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code   <= DEPTH_8;
      lsb_first    <= 1'b1;
      image_width  <= CFG_DATA_W'(1);
      acc          <= '0;
      fill         <= '0;
      column_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEPTH: depth_code  <= cfg_data[2:0];
        REG_LSB:   lsb_first   <= cfg_data[0];
        REG_WIDTH: image_width <= cfg_data;
        default:   depth_code  <= depth_code;
      endcase
      acc          <= '0;
      fill         <= '0;
      column_count <= '0;
    end else if (pixel_go) begin
      column_count <= row_end ? '0 : col_inc;
      if (is_packed) begin
        acc  <= (n_pack != '0) ? 8'd0 : val;
        fill <= row_end ? pad_total[2:0] : fill_inc[2:0];
      end
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_go && gives_job) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (pixel_go) begin
      s1_is24     <= is_24;
      s1_lsb      <= lsb_first;
      s1_in_range <= ({1'b0, pixel} < 9'(PALETTE_ENTRIES));
      s1_row_end  <= row_end;
      s1_count    <= is_24 ? run_count_t'(4) : n_pack;
      s1_val      <= val;
    end
  end

  // Palette: upper bytes of the three levels in one word.
  assign pal_we = accept && (func == FUNC_PALETTE) &&
                  ({1'b0, palette_index} < 9'(PALETTE_ENTRIES));

  pdp_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[AW-1:0]),
    .wdata ({red_level[15:8], green_level[15:8], blue_level[15:8]}),
    .re    (pixel_go && is_24),
    .raddr (pixel[AW-1:0]),
    .rdata (pal_rdata)
  );

  assign red_top   = s1_in_range ? pal_rdata[23:16] : 8'd0;
  assign green_top = s1_in_range ? pal_rdata[15:8]  : 8'd0;
  assign blue_top  = s1_in_range ? pal_rdata[7:0]   : 8'd0;

  // Build the job pushed into the queue.
  assign q_wr_en = s1_move;
  always_comb begin
    q_wr_data.count   = s1_count;
    q_wr_data.row_end = s1_row_end;
    if (!s1_is24) begin
      q_wr_data.bytes = {8'd0, 8'd0, 8'd0, s1_val};
    end else if (s1_lsb) begin
      q_wr_data.bytes = {8'd0, blue_top, green_top, red_top};
    end else begin
      q_wr_data.bytes = {red_top, green_top, blue_top, 8'd0};
    end
  end

endmodule

@@ hdl/pdp_back.sv @@
// Back end of the pixel depth packer: walks each job one byte per cycle
// into the output register while it is empty or popped. Depends on pdp_pkg.
module pdp_back
  import pdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       row_done,
  output logic       last_of_run
);

  logic       out_valid;
  run_count_t idx;
  logic       load;
  logic       is_last;
  logic [7:0] next_byte;

  assign empty     = !out_valid;
  assign load      = q_valid && (!out_valid || pop);
  assign is_last   = (idx == q_job.count - 1'b1);
  assign next_byte = (idx < run_count_t'(4)) ? q_job.bytes[idx[1:0]] : 8'd0;
  assign q_rd      = load && is_last;

  // Byte index within the current job and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= next_byte;
      last_of_run <= is_last;
      row_done    <= is_last && q_job.row_end;
    end
  end

  // The byte index stays inside the job at the head of the queue.
  assert property (@(posedge clk) disable iff (rst) q_valid |-> idx < q_job.count)
    else $error("byte index past end of job");

  // Every queued job yields between one and nine bytes.
  assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_job.count != '0) && (q_job.count <= run_count_t'(9)))
    else $error("job byte count out of range");

  // A row can only end on the last byte of an item.
  assert property (@(posedge clk) disable iff (rst) out_valid && row_done |-> last_of_run)
    else $error("row end without end of run");

  // Retiring a job restarts the byte index.
  assert property (@(posedge clk) disable iff (rst) q_rd |=> idx == '0)
    else $error("byte index not restarted after job");

endmodule

@@ hdl/pixel_depth_packer.sv @@
// Pixel depth packer, top level. An item's bytes pass the front-end stage, the job
// queue and the output byte register. Output runs at one byte per cycle while the
// output is empty or popped, set by the single output byte register. A packed pixel
// yields up to one byte (nine at a row end), a depth-24 pixel four and a palette
// write none. Reset restores the register defaults (8 bits, LSB first, width 1),
// clears packing state and queue; palette contents stay undefined until written.
module pixel_depth_packer
  import pdp_pkg::*;
#(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [7:0]            pixel,
  input  logic [7:0]            palette_index,
  input  logic [15:0]           red_level,
  input  logic [15:0]           green_level,
  input  logic [15:0]           blue_level,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte,
  output logic                  row_done,
  output logic                  last_of_run
);

  logic q_wr_en;
  job_t q_wr_data;
  logic q_full;
  logic q_rd;
  job_t q_job;
  logic q_valid;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  pdp_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .func          (func),
    .pixel         (pixel),
    .palette_index (palette_index),
    .red_level     (red_level),
    .green_level   (green_level),
    .blue_level    (blue_level),
    .q_wr_en       (q_wr_en),
    .q_wr_data     (q_wr_data),
    .q_full        (q_full)
  );

  pdp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_job),
    .valid   (q_valid)
  );

  pdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .row_done    (row_done),
    .last_of_run (last_of_run)
  );

endmodule
